// File: sv/afs_pkg.sv
// Shared types, codes and constants of the aspect-fit nearest-neighbor scaler.
// No dependencies; the top level, afs_ctrl and afs_dp import this package.
package afs_pkg;

  localparam int MAX_SRC_DIM  = 256;
  localparam int MAX_DISP_DIM = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int CENTER_SHIFT = 1;

  localparam int X_W        = 10;
  localparam int Y_W        = 10;
  localparam int PIX_W      = 16;
  localparam int SRC_CFG_W  = 9;
  localparam int DISP_CFG_W = 10;
  localparam int CFG_DW     = 10;
  localparam int CFG_IW     = 3;

  localparam logic [DISP_CFG_W-1:0] DISP_W_RST = 10'd240;
  localparam logic [DISP_CFG_W-1:0] DISP_H_RST = 10'd240;
  localparam logic [SRC_CFG_W-1:0]  SRC_W_RST  = 9'd160;
  localparam logic [SRC_CFG_W-1:0]  SRC_H_RST  = 9'd144;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SCALE_EN = 3'd0,
    CFG_DISP_W   = 3'd1,
    CFG_DISP_H   = 3'd2,
    CFG_SRC_W    = 3'd3,
    CFG_SRC_H    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ACT_DRAW = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OP_FH = 2'd0,
    OP_FW = 2'd1,
    OP_CR = 2'd2,
    OP_RR = 2'd3
  } div_op_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FH,
    ST_FW,
    ST_PICK,
    ST_CR,
    ST_RR,
    ST_READY
  } afs_state_e;

  typedef struct packed {
    action_e           action;
    logic [X_W-1:0]    pos_x;
    logic [Y_W-1:0]    pos_y;
    logic [PIX_W-1:0]  pixel;
  } in_req_t;

  typedef struct packed {
    logic [X_W-1:0]    out_x;
    logic [Y_W-1:0]    out_y;
    logic [PIX_W-1:0]  out_pixel;
    logic              frame_last;
  } out_req_t;

  typedef struct packed {
    logic    in_ready;
    logic    div_start;
    div_op_e start_op;
    logic    div_cap;
    div_op_e cap_op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_busy;
  } ctrl_status_t;

endpackage

// File: sv/afs_stream_if.sv
// Valid/ready stream channel carrying one request of payload type T.
// No dependencies; the payload types come from afs_pkg at instantiation.
interface afs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/aspect_fit_nearest_scaler_top.sv
// Aspect-fit nearest-neighbor scaler top level: controller plus datapath.
// Depends on afs_pkg, afs_stream_if, afs_ctrl and afs_dp.
//
//   channel  dir  handshake        payload
//   in_i     in   valid/ready      action, pos_x, pos_y, pixel
//   out_o    out  valid/ready      out_x, out_y, out_pixel, frame_last
//   cfg      in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// Draw and step requests can be accepted back to back; a result is registered and
// appears in the cycle after its request. After reset and after every config write
// the fit is recomputed by a shared bit-serial divider: four divisions of 25 bits
// at the default parameters, with in_i.ready low meanwhile.
// A held result stalls input only when out_o.ready is low in the same cycle.
module aspect_fit_nearest_scaler_top import afs_pkg::*; #(
  parameter int MaxSrcDim  = MAX_SRC_DIM,
  parameter int MaxDispDim = MAX_DISP_DIM
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  afs_stream_if.sink        in_i,
  afs_stream_if.source      out_o
);
  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  in_req_t      in_data;
  out_req_t     out_data;
  logic         out_valid;

  assign in_data    = in_i.data;
  assign in_i.ready = cmd.in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  afs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .status_i (status),
    .cmd_o    (cmd)
  );

  afs_dp #(
    .MaxSrcDim (MaxSrcDim),
    .MaxDispDim(MaxDispDim)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (status)
  );
endmodule

// File: sv/afs_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by afs_dp for the fit and ratio divisions.
module afs_div #(
  parameter int DvdW = 25,
  parameter int DvsW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);
  localparam int CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DvsW:0]   rem_sh;
  logic [DvsW:0]   diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DvdW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DvsW-1:0] : rem_sh[DvsW-1:0];
      quo_d = {quo_q[DvdW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// File: sv/afs_ctrl.sv
// Controller: sequences the fit divisions after reset and config writes,
// and gates request acceptance. Depends on afs_pkg.
module afs_ctrl import afs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);
  afs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.in_ready  = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.start_op  = OP_FH;
    cmd_o.div_cap   = 1'b0;
    cmd_o.cap_op    = OP_FH;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.start_op  = OP_FH;
        state_d         = ST_FH;
      end
      ST_FH: begin
        cmd_o.div_cap = 1'b1;
        cmd_o.cap_op  = OP_FH;
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.start_op  = OP_FW;
          state_d         = ST_FW;
        end
      end
      ST_FW: begin
        cmd_o.div_cap = 1'b1;
        cmd_o.cap_op  = OP_FW;
        if (status_i.div_done) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd_o.div_start = 1'b1;
        cmd_o.start_op  = OP_CR;
        state_d         = ST_CR;
      end
      ST_CR: begin
        cmd_o.div_cap = 1'b1;
        cmd_o.cap_op  = OP_CR;
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.start_op  = OP_RR;
          state_d         = ST_RR;
        end
      end
      ST_RR: begin
        cmd_o.div_cap = 1'b1;
        cmd_o.cap_op  = OP_RR;
        if (status_i.div_done) begin
          state_d = ST_READY;
        end
      end
      ST_READY: begin
        cmd_o.in_ready = !status_i.out_busy;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    // restart the fit on any register write
    if (cfg_we_i) begin
      state_d         = ST_LOAD;
      cmd_o.div_start = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == ST_LOAD)
    else $error("config write did not restart fit");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FH || state_q == ST_FW || state_q == ST_CR || state_q == ST_RR)
      |-> (status_i.div_busy || status_i.div_done))
    else $error("division state with idle divider");

  a_ready_after_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_READY) |-> $past(status_i.div_done))
    else $error("ready without finished fit");
`endif
endmodule

// File: sv/afs_dp.sv
// Datapath: config registers, fit values, raster counters, source frame
// memory and output register. Depends on afs_pkg and afs_div.
module afs_dp import afs_pkg::*; #(
  parameter int MaxSrcDim  = MAX_SRC_DIM,
  parameter int MaxDispDim = MAX_DISP_DIM
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  in_req_t           in_data_i,
  output logic              out_valid_o,
  output out_req_t          out_data_o,
  input  logic              out_ready_i,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_status_t      status_o
);
  localparam int SW_W      = $clog2(MaxSrcDim + 1);
  localparam int SC_W      = $clog2(MaxSrcDim);
  localparam int DW_W      = $clog2(MaxDispDim + 1);
  localparam int CW1       = DW_W + 1;
  localparam int PROD_W    = DW_W + SW_W;
  localparam int RATIO_W   = SW_W + FRAC_BITS;
  localparam int DVD_W     = (PROD_W > RATIO_W) ? PROD_W : RATIO_W;
  localparam int DVS_W     = (DW_W > SW_W) ? DW_W : SW_W;
  localparam int SUM_W     = (CW1 > X_W) ? CW1 : X_W;
  localparam int MEM_DEPTH = MaxSrcDim * MaxSrcDim;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  logic                  scale_en_q;
  logic [DISP_CFG_W-1:0] disp_w_q, disp_h_q;
  logic [SRC_CFG_W-1:0]  src_w_q, src_h_q;

  logic [SW_W-1:0] sw_c, sh_c;
  logic [DW_W-1:0] dw_c, dh_c;

  logic [DVD_W-1:0] dvd, quo;
  logic [DVS_W-1:0] dvs;
  logic             div_busy, div_done;

  logic [PROD_W-1:0]  fh0_q, fw1_q;
  logic [RATIO_W-1:0] pend_cr_q, pend_rr_q;
  logic               pend_over;
  logic [DW_W-1:0]    pend_fw, pend_fh, pend_offx, pend_offy;

  logic [DW_W-1:0]    act_fw_q, act_fh_q, act_offx_q, act_offy_q;
  logic [RATIO_W-1:0] act_cr_q, act_rr_q;

  logic [DW_W-1:0]    eff_fw, eff_fh, eff_offx, eff_offy;
  logic [RATIO_W-1:0] eff_cr, eff_rr;

  logic [DW_W-1:0]    col_q, col_d, row_q, row_d;
  logic [RATIO_W-1:0] col_acc_q, col_acc_d, row_acc_q, row_acc_d;

  logic in_fire, is_step, frame_start, nonempty;
  logic step_go, step_out, draw_out, draw_wr, step_off;
  logic last_col, last_row;

  logic [SW_W-1:0]   sx_raw, sy_raw;
  logic [SC_W-1:0]   sx, sy;
  logic [MEM_AW-1:0] rd_addr, wr_addr;

  logic [PIX_W-1:0] src_mem [MEM_DEPTH];
  logic [PIX_W-1:0] rd_q, pix_q;
  logic [X_W-1:0]   out_x_q;
  logic [Y_W-1:0]   out_y_q;
  logic             last_q, use_mem_q;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_en_q <= 1'b0;
      disp_w_q   <= DISP_W_RST;
      disp_h_q   <= DISP_H_RST;
      src_w_q    <= SRC_W_RST;
      src_h_q    <= SRC_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE_EN: scale_en_q <= cfg_data_i[0];
        CFG_DISP_W:   disp_w_q   <= cfg_data_i[DISP_CFG_W-1:0];
        CFG_DISP_H:   disp_h_q   <= cfg_data_i[DISP_CFG_W-1:0];
        CFG_SRC_W:    src_w_q    <= cfg_data_i[SRC_CFG_W-1:0];
        CFG_SRC_H:    src_h_q    <= cfg_data_i[SRC_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes to their legal ranges
  always_comb begin
    sw_c = (src_w_q == '0) ? SW_W'(1) :
           ((int'(src_w_q) > MaxSrcDim) ? SW_W'(MaxSrcDim) : SW_W'(src_w_q));
    sh_c = (src_h_q == '0) ? SW_W'(1) :
           ((int'(src_h_q) > MaxSrcDim) ? SW_W'(MaxSrcDim) : SW_W'(src_h_q));
    dw_c = (disp_w_q == '0) ? DW_W'(1) :
           ((int'(disp_w_q) > MaxDispDim) ? DW_W'(MaxDispDim) : DW_W'(disp_w_q));
    dh_c = (disp_h_q == '0) ? DW_W'(1) :
           ((int'(disp_h_q) > MaxDispDim) ? DW_W'(MaxDispDim) : DW_W'(disp_h_q));
  end

  always_comb begin
    pend_over = fh0_q > PROD_W'(dh_c);
    pend_fw   = pend_over ? DW_W'(fw1_q) : dw_c;
    pend_fh   = pend_over ? dh_c : DW_W'(fh0_q);
    pend_offx = pend_over ? DW_W'((dw_c - pend_fw) >> CENTER_SHIFT) : '0;
    pend_offy = pend_over ? '0 : DW_W'((dh_c - pend_fh) >> CENTER_SHIFT);
  end

  always_comb begin
    unique case (cmd_i.start_op)
      OP_FH: begin
        dvd = DVD_W'(PROD_W'(dw_c) * PROD_W'(sh_c));
        dvs = DVS_W'(sw_c);
      end
      OP_FW: begin
        dvd = DVD_W'(PROD_W'(dh_c) * PROD_W'(sw_c));
        dvs = DVS_W'(sh_c);
      end
      OP_CR: begin
        dvd = DVD_W'(RATIO_W'(sw_c) << FRAC_BITS);
        dvs = DVS_W'(pend_fw);
      end
      OP_RR: begin
        dvd = DVD_W'(RATIO_W'(sh_c) << FRAC_BITS);
        dvs = DVS_W'(pend_fh);
      end
    endcase
  end

  afs_div #(
    .DvdW(DVD_W),
    .DvsW(DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_done && cmd_i.div_cap) begin
      unique case (cmd_i.cap_op)
        OP_FH: fh0_q     <= PROD_W'(quo);
        OP_FW: fw1_q     <= PROD_W'(quo);
        OP_CR: pend_cr_q <= (pend_fw == '0) ? '0 : RATIO_W'(quo);
        OP_RR: pend_rr_q <= (pend_fh == '0) ? '0 : RATIO_W'(quo);
      endcase
    end
  end

  always_comb begin
    in_fire     = in_valid_i && cmd_i.in_ready;
    is_step     = in_data_i.action == ACT_STEP;
    frame_start = (col_q == '0) && (row_q == '0);
    eff_fw      = frame_start ? pend_fw   : act_fw_q;
    eff_fh      = frame_start ? pend_fh   : act_fh_q;
    eff_offx    = frame_start ? pend_offx : act_offx_q;
    eff_offy    = frame_start ? pend_offy : act_offy_q;
    eff_cr      = frame_start ? pend_cr_q : act_cr_q;
    eff_rr      = frame_start ? pend_rr_q : act_rr_q;
    nonempty    = (eff_fw != '0) && (eff_fh != '0);
    step_off    = in_fire && is_step && !scale_en_q;
    step_go     = in_fire && is_step && scale_en_q;
    step_out    = step_go && nonempty;
    draw_out    = in_fire && !is_step && !scale_en_q;
    draw_wr     = in_fire && !is_step && scale_en_q &&
                  (int'(in_data_i.pos_x) < int'(sw_c)) &&
                  (int'(in_data_i.pos_y) < int'(sh_c));
    last_col    = (CW1'(col_q) + CW1'(1)) >= CW1'(eff_fw);
    last_row    = (CW1'(row_q) + CW1'(1)) >= CW1'(eff_fh);
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    col_acc_d = col_acc_q;
    row_acc_d = row_acc_q;
    priority if (step_off || (step_go && !nonempty)) begin
      col_d     = '0;
      row_d     = '0;
      col_acc_d = '0;
      row_acc_d = '0;
    end else if (step_out) begin
      if (last_col) begin
        col_d     = '0;
        col_acc_d = '0;
        row_d     = last_row ? '0 : row_q + DW_W'(1);
        row_acc_d = last_row ? '0 : row_acc_q + eff_rr;
      end else begin
        col_d     = col_q + DW_W'(1);
        col_acc_d = col_acc_q + eff_cr;
      end
    end else begin
      col_d = col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      col_acc_q <= '0;
      row_acc_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      col_acc_q <= col_acc_d;
      row_acc_q <= row_acc_d;
    end
  end

  // latch the fit at the start of each frame
  always_ff @(posedge clk_i) begin
    if (step_go && frame_start) begin
      act_fw_q   <= pend_fw;
      act_fh_q   <= pend_fh;
      act_offx_q <= pend_offx;
      act_offy_q <= pend_offy;
      act_cr_q   <= pend_cr_q;
      act_rr_q   <= pend_rr_q;
    end
  end

  always_comb begin
    sx_raw  = col_acc_q[RATIO_W-1:FRAC_BITS];
    sy_raw  = row_acc_q[RATIO_W-1:FRAC_BITS];
    sx      = (sx_raw >= SW_W'(MaxSrcDim)) ? SC_W'(MaxSrcDim - 1) : SC_W'(sx_raw);
    sy      = (sy_raw >= SW_W'(MaxSrcDim)) ? SC_W'(MaxSrcDim - 1) : SC_W'(sy_raw);
    rd_addr = MEM_AW'(MEM_AW'(sy) * MEM_AW'(MaxSrcDim) + MEM_AW'(sx));
    wr_addr = MEM_AW'(MEM_AW'(SC_W'(in_data_i.pos_y)) * MEM_AW'(MaxSrcDim) +
                      MEM_AW'(SC_W'(in_data_i.pos_x)));
  end

  always_ff @(posedge clk_i) begin
    if (draw_wr) begin
      src_mem[wr_addr] <= in_data_i.pixel;
    end
    if (step_out) begin
      rd_q <= src_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_out) begin
      out_x_q   <= in_data_i.pos_x;
      out_y_q   <= in_data_i.pos_y;
      pix_q     <= in_data_i.pixel;
      last_q    <= 1'b0;
      use_mem_q <= 1'b0;
    end else if (step_out) begin
      out_x_q   <= X_W'(SUM_W'(col_q) + SUM_W'(eff_offx));
      out_y_q   <= Y_W'(SUM_W'(row_q) + SUM_W'(eff_offy));
      last_q    <= last_col && last_row;
      use_mem_q <= 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (draw_out || step_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.out_x      = out_x_q;
  assign out_data_o.out_y      = out_y_q;
  assign out_data_o.out_pixel  = use_mem_q ? rd_q : pix_q;
  assign out_data_o.frame_last = last_q;

  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (!out_valid_q || out_ready_i))
    else $error("request accepted over a held result");

  a_count_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q != '0 || row_q != '0) |-> (col_q < act_fw_q && row_q < act_fh_q))
    else $error("raster counter outside fitted frame");

  a_col_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q == '0) |-> (col_acc_q == '0))
    else $error("column accumulator out of step");

  a_row_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q == '0) |-> (row_acc_q == '0))
    else $error("row accumulator out of step");
`endif
endmodule

// File: verif/afs_fit_checker.sv
// Checker for the aspect-fit scaler: tracks register writes, predicts every display
// write from the accepted requests and compares it field by field with the output.
// Depends on afs_pkg only; it sees the channels as plain signals.
module afs_fit_checker
  import afs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  in_req_t           req_i,
  input  logic              wr_valid_i,
  input  logic              wr_ready_i,
  input  out_req_t          wr_i,
  output int                pending_o,
  output int                errors_o
);

  logic [PIX_W-1:0] src_frame [MAX_SRC_DIM*MAX_SRC_DIM];
  bit               scale_en  = 1'b0;
  int unsigned      disp_w    = DISP_W_RST;
  int unsigned      disp_h    = DISP_H_RST;
  int unsigned      src_w     = SRC_W_RST;
  int unsigned      src_h     = SRC_H_RST;
  int unsigned      row_cnt   = 0;
  int unsigned      col_cnt   = 0;
  int unsigned      fit_w, fit_h, col_ratio, row_ratio, off_x, off_y;
  out_req_t         display_writes [$];
  int               errors    = 0;

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic refit();
    int unsigned sw, sh, dw, dh;
    sw    = clamp_dim(src_w, MAX_SRC_DIM);
    sh    = clamp_dim(src_h, MAX_SRC_DIM);
    dw    = clamp_dim(disp_w, MAX_DISP_DIM);
    dh    = clamp_dim(disp_h, MAX_DISP_DIM);
    fit_w = dw;
    fit_h = (dw * sh) / sw;
    if (fit_h > dh) begin
      fit_w = (dh * sw) / sh;
      fit_h = dh;
      off_x = (dw - fit_w) >> CENTER_SHIFT;
      off_y = 0;
    end else begin
      off_x = 0;
      off_y = (dh - fit_h) >> CENTER_SHIFT;
    end
    col_ratio = (fit_w != 0) ? (sw << FRAC_BITS) / fit_w : 0;
    row_ratio = (fit_h != 0) ? (sh << FRAC_BITS) / fit_h : 0;
  endtask

  task automatic predict_request(input in_req_t req);
    out_req_t    wr;
    int unsigned sx, sy;
    bit          last_col, last_row;
    if (req.action == ACT_DRAW) begin
      if (!scale_en) begin
        wr.out_x      = req.pos_x;
        wr.out_y      = req.pos_y;
        wr.out_pixel  = req.pixel;
        wr.frame_last = 1'b0;
        display_writes.push_back(wr);
      end else if (req.pos_x < clamp_dim(src_w, MAX_SRC_DIM) &&
                   req.pos_y < clamp_dim(src_h, MAX_SRC_DIM)) begin
        src_frame[req.pos_y * MAX_SRC_DIM + req.pos_x] = req.pixel;
      end
      return;
    end
    if (!scale_en) begin
      row_cnt = 0;
      col_cnt = 0;
      return;
    end
    if (row_cnt == 0 && col_cnt == 0) refit();
    if (fit_w == 0 || fit_h == 0) begin
      row_cnt = 0;
      col_cnt = 0;
      return;
    end
    sx       = 32'((64'(col_cnt) * 64'(col_ratio)) >> FRAC_BITS);
    sy       = 32'((64'(row_cnt) * 64'(row_ratio)) >> FRAC_BITS);
    last_col = (col_cnt + 1 >= fit_w);
    last_row = (row_cnt + 1 >= fit_h);
    if (sx >= MAX_SRC_DIM) sx = MAX_SRC_DIM - 1;
    if (sy >= MAX_SRC_DIM) sy = MAX_SRC_DIM - 1;
    wr.out_x      = X_W'(col_cnt + off_x);
    wr.out_y      = Y_W'(row_cnt + off_y);
    wr.out_pixel  = src_frame[sy * MAX_SRC_DIM + sx];
    wr.frame_last = last_col && last_row;
    display_writes.push_back(wr);
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endtask

  task automatic check_write(input out_req_t got);
    out_req_t want;
    if (display_writes.size() == 0) begin
      flag_error($sformatf("unexpected write x=%0d y=%0d pixel=%h last=%0b",
                           got.out_x, got.out_y, got.out_pixel, got.frame_last));
      return;
    end
    want = display_writes.pop_front();
    if (got.out_x !== want.out_x)
      flag_error($sformatf("out_x expected %0d got %0d", want.out_x, got.out_x));
    if (got.out_y !== want.out_y)
      flag_error($sformatf("out_y expected %0d got %0d", want.out_y, got.out_y));
    if (got.out_pixel !== want.out_pixel)
      flag_error($sformatf("out_pixel expected %h got %h", want.out_pixel, got.out_pixel));
    if (got.frame_last !== want.frame_last)
      flag_error($sformatf("frame_last expected %0b got %0b", want.frame_last, got.frame_last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_en = 1'b0;
      disp_w   = DISP_W_RST;
      disp_h   = DISP_H_RST;
      src_w    = SRC_W_RST;
      src_h    = SRC_H_RST;
      row_cnt  = 0;
      col_cnt  = 0;
      display_writes.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_SCALE_EN: scale_en = cfg_data_i[0];
          CFG_DISP_W:   disp_w   = cfg_data_i;
          CFG_DISP_H:   disp_h   = cfg_data_i;
          CFG_SRC_W:    src_w    = cfg_data_i[SRC_CFG_W-1:0];
          CFG_SRC_H:    src_h    = cfg_data_i[SRC_CFG_W-1:0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) predict_request(req_i);
      if (wr_valid_i && wr_ready_i) check_write(wr_i);
      pending_o <= display_writes.size();
    end
    errors_o <= errors;
  end

endmodule

// File: verif/testbench.sv
// Top of the scaler testbench: clock, reset, register writes, request stimulus and verdict.
// Depends on afs_pkg, afs_stream_if, the scaler top and afs_fit_checker.
module testbench;
  import afs_pkg::*;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int NUM_PHASES      = 30;
  localparam int ITEMS_PER_PHASE = 33;
  localparam int IDLE_SETTLE     = 4;
  localparam int DRAIN_CYCLES    = 16;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;

  afs_stream_if #(.T(in_req_t))  req_ch ();
  afs_stream_if #(.T(out_req_t)) wr_ch ();

  int pending;
  int errors;
  int cycle_cnt     = 0;
  int send_gap_pct  = 0;
  int recv_gap_pct  = 0;
  bit scaling       = 1'b0;
  int src_cols      = SRC_W_RST;
  int src_rows      = SRC_H_RST;
  bit written [MAX_SRC_DIM*MAX_SRC_DIM];

  aspect_fit_nearest_scaler_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_ch),
    .out_o      (wr_ch)
  );

  afs_fit_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_i       (req_ch.data),
    .wr_valid_i  (wr_ch.valid),
    .wr_ready_i  (wr_ch.ready),
    .wr_i        (wr_ch.data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ch.ready <= 1'b0;
    end else begin
      wr_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  task automatic send_req(input action_e act, input int x, input int y, input int pix);
    in_req_t r;
    int      gap;
    r.action = act;
    r.pos_x  = X_W'(x);
    r.pos_y  = Y_W'(y);
    r.pixel  = PIX_W'(pix);
    if (act == ACT_DRAW && scaling && x < src_cols && y < src_rows)
      written[y * MAX_SRC_DIM + x] = 1'b1;
    gap = 0;
    while ($urandom_range(0, 99) < send_gap_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_random(input action_e act);
    send_req(act, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65535));
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(input bit se, input int dw, input int dh, input int sw, input int sh);
    cfg_reg_e regs [5];
    int       vals [5];
    int       sw_eff, sh_eff;
    regs = '{CFG_SCALE_EN, CFG_DISP_W, CFG_DISP_H, CFG_SRC_W, CFG_SRC_H};
    vals = '{int'(se), dw, dh, sw, sh};
    wait_idle();
    foreach (regs[i]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= CFG_DW'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sw_eff   = sw & 'h1FF;
    sh_eff   = sh & 'h1FF;
    src_cols = (sw_eff < 1) ? 1 : (sw_eff > MAX_SRC_DIM) ? MAX_SRC_DIM : sw_eff;
    src_rows = (sh_eff < 1) ? 1 : (sh_eff > MAX_SRC_DIM) ? MAX_SRC_DIM : sh_eff;
    scaling  = se;
  endtask

  task automatic fill_source();
    for (int y = 0; y < src_rows; y++) begin
      for (int x = 0; x < src_cols; x++) begin
        if (!written[y * MAX_SRC_DIM + x]) send_req(ACT_DRAW, x, y, $urandom_range(0, 65535));
      end
    end
  endtask

  task automatic run_phase(input int p);
    bit se, restart;
    int sw, sh, dw, dh, k;
    se      = (p % 7 != 3);
    sw      = $urandom_range(1, 6);
    sh      = $urandom_range(1, 6);
    dw      = $urandom_range(1, 10);
    dh      = $urandom_range(1, 10);
    restart = $urandom_range(0, 1);
    if ($urandom_range(0, 7) == 0) dw = $urandom_range(1, 1023);
    if ($urandom_range(0, 7) == 0) dh = $urandom_range(1, 1023);
    case (p)
      5: begin
        sw = 300; sh = 1; dw = 1023; dh = 1023; restart = 1'b1;
      end
      12: begin
        sw = 1; sh = 256; dw = 1; dh = 1023; restart = 1'b1;
      end
      20: begin
        sw = 1; sh = 511; dw = 16; dh = 1023; restart = 1'b1;
      end
      25: begin
        sw = 0; sh = 0; dw = 0; dh = 1023; restart = 1'b1;
      end
      27: begin
        sw = 0; sh = 5; dw = 1023; dh = 0; restart = 1'b1;
      end
      default: ;
    endcase
    if (restart) begin
      configure(1'b0, dw, dh, sw, sh);
      send_random(ACT_STEP);
    end
    configure(se, dw, dh, sw, sh);
    if (se) fill_source();
    repeat (ITEMS_PER_PHASE) begin
      k = $urandom_range(0, 99);
      if (se && k < 60) begin
        send_random(ACT_STEP);
      end else if (se && k < 85) begin
        send_req(ACT_DRAW, $urandom_range(0, src_cols - 1), $urandom_range(0, src_rows - 1),
                 $urandom_range(0, 65535));
      end else if (!se && k < 30) begin
        send_random(ACT_STEP);
      end else begin
        send_random(ACT_DRAW);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_SCALE_EN;
    cfg_data_i   = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 22;
    recv_gap_pct = 51;

    // direct writes at the field extremes, then a step with scaling off
    send_req(ACT_DRAW, 0, 0, 'h0000);
    send_req(ACT_DRAW, 1023, 1023, 'hFFFF);
    send_req(ACT_DRAW, 'h2AA, 'h155, 'hA5A5);
    send_req(ACT_DRAW, 'h155, 'h2AA, 'h5A5A);
    send_req(ACT_STEP, 1023, 1023, 'hFFFF);

    // 2x2 source centered on a 4x2 display: stores, drops, one full frame
    configure(1'b1, 4, 2, 2, 2);
    send_req(ACT_DRAW, 0, 0, 'h1111);
    send_req(ACT_DRAW, 1, 0, 'h2222);
    send_req(ACT_DRAW, 0, 1, 'h3333);
    send_req(ACT_DRAW, 1, 1, 'h4444);
    send_req(ACT_DRAW, 2, 0, 'hDEAD);
    send_req(ACT_DRAW, 0, 2, 'hBEEF);
    send_req(ACT_DRAW, 1023, 1023, 'hFFFF);
    repeat (4) send_random(ACT_STEP);

    // empty fitted frames: zero width, then zero height
    configure(1'b1, 1023, 100, 1, 256);
    repeat (2) send_random(ACT_STEP);
    configure(1'b1, 1, 1, 256, 1);
    repeat (2) send_random(ACT_STEP);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_PHASES / 3) begin
        send_gap_pct = 22;
        recv_gap_pct = 51;
      end else if (p < 2 * NUM_PHASES / 3) begin
        send_gap_pct = 51;
        recv_gap_pct = 22;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      run_phase(p);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
